// ----- rtl/core/gsf_pkg.sv -----
// Shared constants, types and state codes for the grey span fill block.
// No dependencies; every other file in rtl/core refers to this package.
package gsf_pkg;

  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 160;
  localparam int PIX_PER_WORD  = 8;
  localparam int WORDS_PER_ROW = (SCREEN_WIDTH + PIX_PER_WORD - 1) / PIX_PER_WORD;
  localparam int MAX_WRITES    = 21;

  localparam int FIELD_W  = 8;
  localparam int COLOUR_W = 2;
  localparam int ADDR_W   = 12;
  localparam int DATA_W   = 16;
  localparam int PIX_W    = 3;   // pixel position inside a word
  localparam int COL_W    = 11;  // holds a screen width up to 1024 and x + width
  localparam int WORD_W   = 6;   // column word of a pixel below 512
  localparam int PROD_W   = 16;  // row times words per row
  localparam int CNT_W    = $clog2(MAX_WRITES);

  // Address of column word 0 of the last row, used for rows off the screen.
  localparam logic [ADDR_W-1:0] ROW_CLAMP_ADDR =
    ADDR_W'((SCREEN_HEIGHT - 1) * WORDS_PER_ROW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SETUP,
    ST_EMIT
  } gsf_state_t;

  // Mask request for one word write.
  typedef struct packed {
    logic             zero;    // empty span: no pixel written
    logic [PIX_W-1:0] lo;      // first pixel written in the word
    logic             use_hi;  // word holds the right edge of the span
    logic [PIX_W-1:0] hi_m1;   // last pixel written at the right edge
  } mask_ctl_t;

endpackage

// ----- rtl/core/gsf_ifs.sv -----
// Valid/ready channel interfaces for span words in and masked writes out.
// Depends on gsf_pkg for field widths.
interface gsf_in_if;
  logic                          valid;
  logic                          ready;
  logic [gsf_pkg::FIELD_W-1:0]   x_start;
  logic [gsf_pkg::FIELD_W-1:0]   span_width;
  logic [gsf_pkg::FIELD_W-1:0]   row_index;
  logic [gsf_pkg::COLOUR_W-1:0]  colour;

  modport source (output valid, x_start, span_width, row_index, colour, input ready);
  modport sink   (input valid, x_start, span_width, row_index, colour, output ready);
endinterface

interface gsf_out_if;
  logic                        valid;
  logic                        ready;
  logic [gsf_pkg::ADDR_W-1:0]  word_address;
  logic [gsf_pkg::DATA_W-1:0]  fill_data;
  logic [gsf_pkg::DATA_W-1:0]  pixel_mask;
  logic                        last_write;

  modport source (output valid, word_address, fill_data, pixel_mask, last_write,
                  input ready);
  modport sink   (input valid, word_address, fill_data, pixel_mask, last_write,
                  output ready);
endinterface

// ----- rtl/core/gsf_mask_gen.sv -----
// Pixel mask generator: builds the 16-bit write mask of one framebuffer word.
// Depends on gsf_pkg for mask_ctl_t and widths.
module gsf_mask_gen (
  input  gsf_pkg::mask_ctl_t            ctl,
  output logic [gsf_pkg::DATA_W-1:0]    mask
);

  logic [gsf_pkg::DATA_W-1:0] left_mask;
  logic [gsf_pkg::DATA_W-1:0] right_mask;
  logic [3:0]                 left_sh;
  logic [3:0]                 right_sh;

  // Leftmost pixel sits in the top two bits.
  assign left_sh  = {ctl.lo, 1'b0};
  assign right_sh = 4'd14 - {ctl.hi_m1, 1'b0};

  always_comb begin
    left_mask  = {gsf_pkg::DATA_W{1'b1}} >> left_sh;
    right_mask = ctl.use_hi ? ({gsf_pkg::DATA_W{1'b1}} << right_sh)
                            : {gsf_pkg::DATA_W{1'b1}};
    mask       = ctl.zero ? '0 : (left_mask & right_mask);
  end

endmodule

// ----- rtl/core/grey_span_fill_masks.sv -----
// Horizontal span fill for a 2-bit-per-pixel framebuffer, eight pixels per word.
// The span word passes through ST_MUL and ST_SETUP before ST_EMIT loads its first write word.
// Each span gives 1..20 write words, one word per cycle from the address and column
// incrementers while the output is taken; a new span is taken only back in idle.
// Reset (rst_n low, synchronous): sequencer to idle, output channel empty.
// Depends on gsf_pkg, gsf_in_if/gsf_out_if (gsf_ifs.sv) and gsf_mask_gen.
module grey_span_fill_masks (
  input  logic            clk,
  input  logic            rst_n,
  gsf_in_if.sink          in_ch,
  gsf_out_if.source       out_ch
);

  // Sequencer state
  gsf_pkg::gsf_state_t state_r, state_nxt;

  // Captured span word
  logic [gsf_pkg::FIELD_W-1:0]  x_r, x_nxt;
  logic [gsf_pkg::FIELD_W-1:0]  w_r, w_nxt;
  logic [gsf_pkg::FIELD_W-1:0]  row_r, row_nxt;
  logic [gsf_pkg::COLOUR_W-1:0] colour_r, colour_nxt;

  // Span walk state
  logic [gsf_pkg::ADDR_W-1:0]   base_r, base_nxt;
  logic [gsf_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [gsf_pkg::WORD_W-1:0]   word_r, word_nxt;
  logic [gsf_pkg::WORD_W-1:0]   last_word_r, last_word_nxt;
  logic [gsf_pkg::PIX_W-1:0]    hi_m1_r, hi_m1_nxt;
  logic [gsf_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                         zero_r, zero_nxt;
  logic                         first_r, first_nxt;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic [gsf_pkg::ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [gsf_pkg::DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [gsf_pkg::DATA_W-1:0]   out_mask_r, out_mask_nxt;
  logic                         out_last_r, out_last_nxt;

  // Datapath helpers
  logic [gsf_pkg::PROD_W-1:0]   row_prod;
  logic [gsf_pkg::COL_W-1:0]    col_sum;
  logic [gsf_pkg::COL_W-1:0]    col_right;
  logic [gsf_pkg::COL_W-1:0]    col_right_m1;
  logic [gsf_pkg::ADDR_W-1:0]   col_offset;
  logic                         row_oob;
  logic                         x_oob;
  logic                         span_empty;
  logic                         at_right;
  logic                         at_last;
  logic                         load;
  gsf_pkg::mask_ctl_t           mask_ctl;
  logic [gsf_pkg::DATA_W-1:0]   word_mask;

  localparam logic [gsf_pkg::COL_W-1:0] SW_C = gsf_pkg::COL_W'(gsf_pkg::SCREEN_WIDTH);
  localparam logic [gsf_pkg::COL_W-1:0] SH_C = gsf_pkg::COL_W'(gsf_pkg::SCREEN_HEIGHT);

  assign in_ch.ready         = (state_r == gsf_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.word_address = out_addr_r;
  assign out_ch.fill_data    = out_data_r;
  assign out_ch.pixel_mask   = out_mask_r;
  assign out_ch.last_write   = out_last_r;

  // Row start address: one multiply by the constant row pitch.
  assign row_prod = gsf_pkg::PROD_W'(row_r) * gsf_pkg::PROD_W'(gsf_pkg::WORDS_PER_ROW);

  // Clip the right end of the span to the row end.
  assign col_sum      = gsf_pkg::COL_W'(x_r) + gsf_pkg::COL_W'(w_r);
  assign col_right    = (col_sum > SW_C) ? SW_C : col_sum;
  assign col_right_m1 = col_right - gsf_pkg::COL_W'(1);

  assign row_oob    = (gsf_pkg::COL_W'(row_r) >= SH_C);
  assign x_oob      = (gsf_pkg::COL_W'(x_r) >= SW_C);
  assign span_empty = (w_r == '0);

  // A start past the row end lands on the last word of the row.
  assign col_offset = x_oob ? gsf_pkg::ADDR_W'(gsf_pkg::WORDS_PER_ROW - 1)
                            : gsf_pkg::ADDR_W'(x_r[gsf_pkg::FIELD_W-1:gsf_pkg::PIX_W]);

  // Current word's mask request
  assign at_right = (word_r == last_word_r);
  assign at_last  = zero_r || at_right ||
                    (count_r == gsf_pkg::CNT_W'(gsf_pkg::MAX_WRITES - 1));
  assign load     = !out_valid_r || out_ch.ready;

  always_comb begin
    mask_ctl.zero   = zero_r;
    mask_ctl.lo     = first_r ? x_r[gsf_pkg::PIX_W-1:0] : '0;
    mask_ctl.use_hi = at_right;
    mask_ctl.hi_m1  = hi_m1_r;
  end

  gsf_mask_gen u_mask_gen (
    .ctl  (mask_ctl),
    .mask (word_mask)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gsf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    w_r         <= w_nxt;
    row_r       <= row_nxt;
    colour_r    <= colour_nxt;
    base_r      <= base_nxt;
    addr_r      <= addr_nxt;
    word_r      <= word_nxt;
    last_word_r <= last_word_nxt;
    hi_m1_r     <= hi_m1_nxt;
    count_r     <= count_nxt;
    zero_r      <= zero_nxt;
    first_r     <= first_nxt;
    out_addr_r  <= out_addr_nxt;
    out_data_r  <= out_data_nxt;
    out_mask_r  <= out_mask_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    // Hold everything by default.
    state_nxt     = state_r;
    x_nxt         = x_r;
    w_nxt         = w_r;
    row_nxt       = row_r;
    colour_nxt    = colour_r;
    base_nxt      = base_r;
    addr_nxt      = addr_r;
    word_nxt      = word_r;
    last_word_nxt = last_word_r;
    hi_m1_nxt     = hi_m1_r;
    count_nxt     = count_r;
    zero_nxt      = zero_r;
    first_nxt     = first_r;
    out_addr_nxt  = out_addr_r;
    out_data_nxt  = out_data_r;
    out_mask_nxt  = out_mask_r;
    out_last_nxt  = out_last_r;

    // Drop the output word once the sink takes it.
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      gsf_pkg::ST_IDLE: begin
        // Capture the span word.
        if (in_ch.valid) begin
          x_nxt      = in_ch.x_start;
          w_nxt      = in_ch.span_width;
          row_nxt    = in_ch.row_index;
          colour_nxt = in_ch.colour;
          state_nxt  = gsf_pkg::ST_MUL;
        end
      end

      gsf_pkg::ST_MUL: begin
        // Register the row start before the column add.
        base_nxt  = row_prod[gsf_pkg::ADDR_W-1:0];
        state_nxt = gsf_pkg::ST_SETUP;
      end

      gsf_pkg::ST_SETUP: begin
        // Settle the first address, the word range and the special cases.
        addr_nxt      = row_oob ? gsf_pkg::ROW_CLAMP_ADDR : (base_r + col_offset);
        zero_nxt      = row_oob || x_oob || span_empty;
        word_nxt      = gsf_pkg::WORD_W'(x_r[gsf_pkg::FIELD_W-1:gsf_pkg::PIX_W]);
        last_word_nxt = col_right_m1[gsf_pkg::PIX_W+gsf_pkg::WORD_W-1:gsf_pkg::PIX_W];
        hi_m1_nxt     = col_right_m1[gsf_pkg::PIX_W-1:0];
        count_nxt     = '0;
        first_nxt     = 1'b1;
        state_nxt     = gsf_pkg::ST_EMIT;
      end

      gsf_pkg::ST_EMIT: begin
        // Emit one masked write per free output slot, then advance the walk.
        if (load) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = addr_r;
          out_data_nxt  = {(gsf_pkg::DATA_W / gsf_pkg::COLOUR_W){colour_r}};
          out_mask_nxt  = word_mask;
          out_last_nxt  = at_last;
          addr_nxt      = addr_r + gsf_pkg::ADDR_W'(1);
          word_nxt      = word_r + gsf_pkg::WORD_W'(1);
          count_nxt     = count_r + gsf_pkg::CNT_W'(1);
          first_nxt     = 1'b0;
          if (at_last) begin
            state_nxt = gsf_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = gsf_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // An accepted span always starts with the row multiply.
  a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == gsf_pkg::ST_MUL))
    else $error("accepted span did not start the row multiply");

  // The walk never runs past the write budget of one span.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gsf_pkg::ST_EMIT) |->
      (count_r <= gsf_pkg::CNT_W'(gsf_pkg::MAX_WRITES - 1)))
    else $error("span walk exceeded the write budget");

  // A non-empty span never walks past its right edge word.
  a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gsf_pkg::ST_EMIT && !zero_r) |-> (word_r <= last_word_r))
    else $error("span walk passed the right edge word");

  // Loading the final write returns the sequencer to idle with that write marked.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gsf_pkg::ST_EMIT && load && at_last) |=>
      (state_r == gsf_pkg::ST_IDLE && out_valid_r && out_last_r))
    else $error("final write did not end the span");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for grey_span_fill_masks: directed and random spans go in on
// the span channel, and every masked write that comes out is checked field by field.
// Depends on gsf_pkg, the channel interfaces in gsf_ifs.sv and the grey_span_fill_masks RTL.
module tb;

  // Worst run: ~130 spans, each up to 20 writes under receiver stalls and gaps, plus one long hold.
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;

  // One span word as driven on the input channel.
  typedef struct packed {
    logic [gsf_pkg::FIELD_W-1:0]  x_start;
    logic [gsf_pkg::FIELD_W-1:0]  span_width;
    logic [gsf_pkg::FIELD_W-1:0]  row_index;
    logic [gsf_pkg::COLOUR_W-1:0] colour;
  } span_t;

  // One masked framebuffer write as seen on the output channel.
  typedef struct packed {
    logic [gsf_pkg::ADDR_W-1:0] word_address;
    logic [gsf_pkg::DATA_W-1:0] fill_data;
    logic [gsf_pkg::DATA_W-1:0] pixel_mask;
    logic                       last_write;
  } fill_write_t;

  logic clk;
  logic rst_n;

  gsf_in_if  in_ch();
  gsf_out_if out_ch();

  grey_span_fill_masks dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  span_t       span_q[$];    // spans waiting to be offered; front is on the bus
  fill_write_t write_q[$];   // writes owed by the block, oldest first

  int         err_cnt   = 0;
  int         cycle_cnt = 0;
  bit         span_taken;    // span word accepted at the last rising edge
  bit         steady;        // no sender gaps and no receiver stalls
  bit         hold_req;      // ask the receiver for its long hold-off
  int         hold_cnt   = 0;
  int         burst_left = 0;
  int         gap_left   = 0;
  logic [7:0] stall_pat  = 8'hFF;
  int         pat_age    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out every write one span causes and queue them in order.
  function automatic void predict_fill(span_t s);
    fill_write_t wr;
    int unsigned x, row, right, first_w, last_w, base, lo, hi, n;
    x   = 32'(s.x_start);
    row = 32'(s.row_index);
    wr.fill_data  = {8{s.colour}};
    wr.pixel_mask = '0;
    wr.last_write = 1'b1;
    // Row off the screen: one empty write at the first word of the last row.
    if (row >= gsf_pkg::SCREEN_HEIGHT) begin
      wr.word_address = gsf_pkg::ADDR_W'((gsf_pkg::SCREEN_HEIGHT - 1) *
                                         gsf_pkg::WORDS_PER_ROW);
      write_q.push_back(wr);
      return;
    end
    // Start past the row end: one empty write at the last word of the row.
    if (x >= gsf_pkg::SCREEN_WIDTH) begin
      wr.word_address = gsf_pkg::ADDR_W'(row * gsf_pkg::WORDS_PER_ROW +
                                         gsf_pkg::WORDS_PER_ROW - 1);
      write_q.push_back(wr);
      return;
    end
    // Clip the right end to the row.
    right = x + 32'(s.span_width);
    if (right > gsf_pkg::SCREEN_WIDTH)
      right = gsf_pkg::SCREEN_WIDTH;
    // Zero width: one empty write at the word holding the start pixel.
    if (right <= x) begin
      wr.word_address = gsf_pkg::ADDR_W'(row * gsf_pkg::WORDS_PER_ROW +
                                         x / gsf_pkg::PIX_PER_WORD);
      write_q.push_back(wr);
      return;
    end
    first_w = x / gsf_pkg::PIX_PER_WORD;
    last_w  = (right - 1) / gsf_pkg::PIX_PER_WORD;
    n       = 0;
    for (int unsigned wi = first_w; wi <= last_w; wi++) begin
      base = wi * gsf_pkg::PIX_PER_WORD;
      lo   = (x > base) ? x - base : 0;
      hi   = (right < base + gsf_pkg::PIX_PER_WORD) ? right - base : gsf_pkg::PIX_PER_WORD;
      wr.word_address = gsf_pkg::ADDR_W'(row * gsf_pkg::WORDS_PER_ROW + wi);
      // Leftmost pixel sits in the top two bits, so trim from both ends.
      wr.pixel_mask   = (16'hFFFF >> (2 * lo)) &
                        (16'hFFFF << (2 * (gsf_pkg::PIX_PER_WORD - hi)));
      wr.last_write   = (wi == last_w) || (n == gsf_pkg::MAX_WRITES - 1);
      write_q.push_back(wr);
      n++;
      if (wr.last_write)
        break;
    end
  endfunction

  // Random span, weighted toward spans that land on the screen.
  function automatic span_t rand_span();
    span_t s;
    int    kind;
    kind         = $urandom_range(0, 19);
    s.colour     = gsf_pkg::COLOUR_W'($urandom_range(0, 3));
    s.x_start    = gsf_pkg::FIELD_W'($urandom_range(0, gsf_pkg::SCREEN_WIDTH - 1));
    s.row_index  = gsf_pkg::FIELD_W'($urandom_range(0, gsf_pkg::SCREEN_HEIGHT - 1));
    s.span_width = ($urandom_range(0, 4) < 3) ?
                   gsf_pkg::FIELD_W'($urandom_range(1, 24)) :
                   gsf_pkg::FIELD_W'($urandom_range(0, gsf_pkg::SCREEN_WIDTH));
    case (kind)
      14, 15: s.span_width = gsf_pkg::FIELD_W'($urandom_range(150, 255)); // run past row end
      16:     s.x_start    = gsf_pkg::FIELD_W'($urandom_range(gsf_pkg::SCREEN_WIDTH, 255));
      17:     s.row_index  = gsf_pkg::FIELD_W'($urandom_range(gsf_pkg::SCREEN_HEIGHT, 255));
      18:     s.span_width = '0;
      19:     s = {gsf_pkg::FIELD_W'($urandom), gsf_pkg::FIELD_W'($urandom),
                   gsf_pkg::FIELD_W'($urandom), gsf_pkg::COLOUR_W'($urandom)}; // raw noise
      default: ;
    endcase
    return s;
  endfunction

  function automatic void add_span(int x, int w, int row, int c);
    span_t s;
    s.x_start    = gsf_pkg::FIELD_W'(x);
    s.span_width = gsf_pkg::FIELD_W'(w);
    s.row_index  = gsf_pkg::FIELD_W'(row);
    s.colour     = gsf_pkg::COLOUR_W'(c);
    span_q.push_back(s);
  endfunction

  // Hold until every queued span is taken and every owed write has come out;
  // leave on a rising edge so the caller's updates stay clear of the drivers.
  task automatic wait_idle();
    do @(negedge clk); while (span_q.size() != 0 || write_q.size() != 0);
    @(posedge clk);
  endtask

  // Monitor: sample both channels at the rising edge, predict on every accepted
  // span word and check every accepted write word against the oldest prediction.
  always @(posedge clk) begin
    fill_write_t got;
    fill_write_t want;
    span_t       s;
    span_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      s = {in_ch.x_start, in_ch.span_width, in_ch.row_index, in_ch.colour};
      predict_fill(s);
      span_q.delete(0);   // advance past the word just taken
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.word_address, out_ch.fill_data, out_ch.pixel_mask, out_ch.last_write};
      if (write_q.size() == 0) begin
        $error("unexpected write: word_address %0d pixel_mask %h",
               got.word_address, got.pixel_mask);
        err_cnt++;
      end else begin
        want = write_q.pop_front();
        if (got.word_address !== want.word_address) begin
          $error("word_address: expected %0d, got %0d", want.word_address, got.word_address);
          err_cnt++;
        end
        if (got.fill_data !== want.fill_data) begin
          $error("fill_data: expected %h, got %h", want.fill_data, got.fill_data);
          err_cnt++;
        end
        if (got.pixel_mask !== want.pixel_mask) begin
          $error("pixel_mask: expected %h, got %h", want.pixel_mask, got.pixel_mask);
          err_cnt++;
        end
        if (got.last_write !== want.last_write) begin
          $error("last_write: expected %0b, got %0b", want.last_write, got.last_write);
          err_cnt++;
        end
      end
    end
  end

  // Driver: offer spans from the queue in bursts of random length with random
  // gaps between them; hold a word on the bus until the block takes it.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !span_taken) begin
      // hold the current word
    end else begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap_left   = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (span_q.size() > 0) begin
        in_ch.valid      <= 1'b1;
        in_ch.x_start    <= span_q[0].x_start;
        in_ch.span_width <= span_q[0].span_width;
        in_ch.row_index  <= span_q[0].row_index;
        in_ch.colour     <= span_q[0].colour;
        burst_left--;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall on a rotating 8-bit pattern that is redrawn now and then;
  // once asked, drop ready for a long stretch so the block backs up its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_ch.ready <= 1'b0;
      hold_cnt++;
    end else if (steady) begin
      out_ch.ready <= 1'b1;
    end else begin
      if (pat_age == 0) begin
        stall_pat = 8'($urandom_range(1, 255));   // never all stalls
        pat_age   = $urandom_range(16, 64);
      end
      stall_pat    = {stall_pat[6:0], stall_pat[7]};
      out_ch.ready <= stall_pat[0];
      pat_age--;
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("grey_span_fill_masks test failed");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value before the first edge.
    rst_n            = 1'b0;
    steady           = 1'b1;
    hold_req         = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.x_start    = '0;
    in_ch.span_width = '0;
    in_ch.row_index  = '0;
    in_ch.colour     = '0;
    out_ch.ready     = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed spans, back to back with the receiver always ready.
    add_span(0,   160, 0,   3);   // full aligned row
    add_span(1,   160, 159, 2);   // unaligned, clipped at row end
    add_span(0,   0,   0,   0);   // zero width at the first word
    add_span(159, 0,   5,   1);   // zero width at the last word
    add_span(159, 1,   159, 3);   // last pixel of the screen
    add_span(159, 255, 10,  2);   // widest width, clipped to one pixel
    add_span(160, 4,   7,   1);   // start just past the row
    add_span(255, 255, 255, 3);   // everything off the screen
    add_span(10,  5,   160, 2);   // row just past the screen
    add_span(20,  3,   255, 0);   // last row code
    add_span(3,   2,   1,   1);   // inside one word
    add_span(8,   8,   2,   2);   // exactly one aligned word
    add_span(7,   1,   3,   3);   // rightmost pixel of a word
    add_span(0,   8,   4,   0);   // first word, full mask
    add_span(5,   10,  6,   1);   // two partial words
    add_span(6,   13,  100, 2);   // partial edges around one full word
    add_span(152, 8,   120, 3);   // last word of the row, aligned
    add_span(12,  100, 77,  1);
    add_span(128, 32,  128, 2);   // high bit of start and row
    add_span(33,  127, 64,  0);
    wait_idle();

    // Random spans with sender gaps and receiver stalls.
    steady = 1'b0;
    repeat (50) span_q.push_back(rand_span());
    wait_idle();

    // Long receiver hold-off while the sender keeps offering spans.
    hold_req = 1'b1;
    repeat (20) span_q.push_back(rand_span());
    wait_idle();

    // More random spans under the normal idling pattern.
    repeat (40) span_q.push_back(rand_span());
    wait_idle();

    // Let any stray write show up before calling the result.
    repeat (10) @(posedge clk);
    if (err_cnt == 0)
      $display("grey_span_fill_masks test passed");
    else
      $display("grey_span_fill_masks test failed");
    $finish;
  end

endmodule
